>>> hw/rtl/eptm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eptm_pkg
// Shared types and constants of the 8-bit PWM timer: operation codes,
// waveform and output modes, register map, config bundle and prescaler limits.
// ----------------------------------------------------------------------------
package eptm_pkg;

    // Prescaler counter width (largest divisor is 1024)
    localparam int PRESC_W = 10;
    // APB address width, six 32-bit registers
    localparam int ADDR_W  = 5;

    // Item operation codes
    typedef logic [2:0] t_func;
    localparam t_func FN_TICK         = 3'd0;
    localparam t_func FN_WR_COUNT     = 3'd1;
    localparam t_func FN_WR_COMPARE   = 3'd2;
    localparam t_func FN_CLEAR_FLAGS  = 3'd3;
    localparam t_func FN_RESET_COUNTS = 3'd4;

    // Waveform modes
    typedef logic [1:0] t_wave;
    localparam t_wave WM_NORMAL   = 2'd0;
    localparam t_wave WM_PC_PWM   = 2'd1;
    localparam t_wave WM_CTC      = 2'd2;
    localparam t_wave WM_FAST_PWM = 2'd3;

    // Compare output modes
    typedef logic [1:0] t_omode;
    localparam t_omode OM_OFF    = 2'd0;
    localparam t_omode OM_TOGGLE = 2'd1;
    localparam t_omode OM_CLEAR  = 2'd2;
    localparam t_omode OM_SET    = 2'd3;

    // Register indexes (byte address = 4 * index)
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_WAVE_MODE   = 3'd0;
    localparam t_reg_idx REG_OUTPUT_MODE = 3'd1;
    localparam t_reg_idx REG_CLOCK_SEL   = 3'd2;
    localparam t_reg_idx REG_OVF_IRQ_EN  = 3'd3;
    localparam t_reg_idx REG_CMP_IRQ_EN  = 3'd4;
    localparam t_reg_idx REG_EXT_EN      = 3'd5;

    // Configuration bundle from the register block
    typedef struct packed {
        t_wave      wave_mode;
        t_omode     output_mode;
        logic [2:0] clock_select;
        logic       ovf_irq_en;
        logic       cmp_irq_en;
        logic       ext_en;
    } t_cfg;

    // Terminal prescaler count (divisor - 1) per clock select code
    function automatic logic [PRESC_W-1:0] presc_limit(input logic [2:0] cs);
        logic [PRESC_W-1:0] lim;
        case (cs)
            3'd1:    lim = 10'd0;
            3'd2:    lim = 10'd7;
            3'd3:    lim = 10'd31;
            3'd4:    lim = 10'd63;
            3'd5:    lim = 10'd127;
            3'd6:    lim = 10'd255;
            3'd7:    lim = 10'd1023;
            default: lim = 10'd0;
        endcase
        return lim;
    endfunction

endpackage

>>> hw/rtl/eight_bit_pwm_timer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_pwm_timer_unit
// 8-bit timer/counter with prescaler, four waveform modes, compare output
// pin, overflow/compare flags with interrupt request and extension counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one item per transfer: a clock
//   tick, a counter write, a compare write, a flag clear or a count reset.
//   Output channel (o_valid / i_stall) returns one result per item: the
//   counter, active compare value, pin, flags, irq and extension count as
//   they stand after that item.
//   Items pass the input register, then the result register. Throughput:
//   one item per cycle unless stalled; one logic pass updates the timer state.
//   When the receiver stalls, the result register holds and the input
//   register keeps one more item, then o_stall rises until the result goes.
//   Configuration goes over the APB port (registers at 4*index) while no
//   item is in flight; pready is always high.
//   Synchronous active-low reset zeroes timer state, config and valid bits;
//   the block accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
module eight_bit_pwm_timer_unit
    import eptm_pkg::*;
#(
    parameter int COUNT_WIDTH  = 8,
    parameter int EXTEND_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0]              i_func,
    input  logic [7:0]              i_value,
    // output channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [COUNT_WIDTH-1:0]  o_count_value,
    output logic [COUNT_WIDTH-1:0]  o_compare_value,
    output logic                    o_pin_level,
    output logic                    o_overflow_flag,
    output logic                    o_compare_flag,
    output logic                    o_irq,
    output logic [EXTEND_WIDTH-1:0] o_extended_count
);

    t_cfg cfg;

    // Input register
    logic       r_s1_valid;
    t_func      r_s1_func;
    logic [7:0] r_s1_value;
    logic       s1_adv;
    logic       s1_fire;
    logic       in_xfer;

    // Result register
    logic                    r_o_valid;
    logic [COUNT_WIDTH-1:0]  r_o_count;
    logic [COUNT_WIDTH-1:0]  r_o_compare;
    logic                    r_o_pin;
    logic                    r_o_ovf;
    logic                    r_o_cmp;
    logic                    r_o_irq;
    logic [EXTEND_WIDTH-1:0] r_o_event;

    logic                    advance;
    logic [COUNT_WIDTH-1:0]  nx_count;
    logic [COUNT_WIDTH-1:0]  nx_compare;
    logic                    nx_pin;
    logic                    nx_ovf;
    logic                    nx_cmp;
    logic [EXTEND_WIDTH-1:0] nx_event;

    eptm_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake control
    assign s1_adv  = !r_o_valid || !i_stall;
    assign s1_fire = r_s1_valid && s1_adv;
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_xfer = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_func  <= i_func;
            r_s1_value <= i_value;
        end
    end

    eptm_prescaler u_presc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (s1_fire && r_s1_func == FN_TICK),
        .i_clock_select (cfg.clock_select),
        .o_advance      (advance)
    );

    eptm_core #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .EXTEND_WIDTH (EXTEND_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_fire    (s1_fire),
        .i_func    (r_s1_func),
        .i_value   (r_s1_value),
        .i_advance (advance),
        .o_count   (nx_count),
        .o_compare (nx_compare),
        .o_pin     (nx_pin),
        .o_ovf     (nx_ovf),
        .o_cmp     (nx_cmp),
        .o_event   (nx_event)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_fire) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_o_count   <= nx_count;
            r_o_compare <= nx_compare;
            r_o_pin     <= nx_pin;
            r_o_ovf     <= nx_ovf;
            r_o_cmp     <= nx_cmp;
            r_o_irq     <= (nx_ovf & cfg.ovf_irq_en) | (nx_cmp & cfg.cmp_irq_en);
            r_o_event   <= nx_event;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_count_value    = r_o_count;
    assign o_compare_value  = r_o_compare;
    assign o_pin_level      = r_o_pin;
    assign o_overflow_flag  = r_o_ovf;
    assign o_compare_flag   = r_o_cmp;
    assign o_irq            = r_o_irq;
    assign o_extended_count = r_o_event;

`ifndef SYNTHESIS
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |=> r_o_valid)
        else $error("stalled result dropped");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_o_valid))
        else $error("input stalled with free space");
    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_o_valid)
        else $error("transfer lost between stages");
`endif

endmodule

>>> hw/rtl/eptm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eptm_cfg_regs
// APB register block: mode, output mode, clock select, interrupt enables and
// extension counter enable. Zero wait states, read-back of all registers.
// ----------------------------------------------------------------------------
module eptm_cfg_regs
    import eptm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_WAVE_MODE:   r_cfg.wave_mode    <= pwdata[1:0];
                REG_OUTPUT_MODE: r_cfg.output_mode  <= pwdata[1:0];
                REG_CLOCK_SEL:   r_cfg.clock_select <= pwdata[2:0];
                REG_OVF_IRQ_EN:  r_cfg.ovf_irq_en   <= pwdata[0];
                REG_CMP_IRQ_EN:  r_cfg.cmp_irq_en   <= pwdata[0];
                REG_EXT_EN:      r_cfg.ext_en       <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (idx)
            REG_WAVE_MODE:   prdata = {30'd0, r_cfg.wave_mode};
            REG_OUTPUT_MODE: prdata = {30'd0, r_cfg.output_mode};
            REG_CLOCK_SEL:   prdata = {29'd0, r_cfg.clock_select};
            REG_OVF_IRQ_EN:  prdata = {31'd0, r_cfg.ovf_irq_en};
            REG_CMP_IRQ_EN:  prdata = {31'd0, r_cfg.cmp_irq_en};
            REG_EXT_EN:      prdata = {31'd0, r_cfg.ext_en};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/eptm_prescaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eptm_prescaler
// Clock prescaler: counts tick transfers and flags the one that advances the
// timer, according to the selected divisor.
// ----------------------------------------------------------------------------
module eptm_prescaler
    import eptm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  logic [2:0] i_clock_select,
    output logic       o_advance
);

    logic [PRESC_W-1:0] r_presc;
    logic [PRESC_W-1:0] n_presc;
    logic               run;
    logic               hit;

    assign run = i_tick & (i_clock_select != 3'd0);
    // count may sit above the limit after a divisor change: >= catches it
    assign hit = (r_presc >= presc_limit(i_clock_select));

    always_comb begin
        n_presc = r_presc;
        if (run) begin
            n_presc = hit ? '0 : r_presc + PRESC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc <= '0;
        end else begin
            r_presc <= n_presc;
        end
    end

    assign o_advance = run & hit;

endmodule

>>> hw/rtl/eptm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eptm_core
// Timer state and its combinational update: counter, direction, compare
// buffer/active, pin, flags and extension counter. Presents the state after
// the current item for the result register.
// ----------------------------------------------------------------------------
module eptm_core
    import eptm_pkg::*;
#(
    parameter int COUNT_WIDTH  = 8,
    parameter int EXTEND_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_fire,
    input  t_func                   i_func,
    input  logic [7:0]              i_value,
    input  logic                    i_advance,
    output logic [COUNT_WIDTH-1:0]  o_count,
    output logic [COUNT_WIDTH-1:0]  o_compare,
    output logic                    o_pin,
    output logic                    o_ovf,
    output logic                    o_cmp,
    output logic [EXTEND_WIDTH-1:0] o_event
);

    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0]  r_count,   n_count;
    logic                    r_down,    n_down;
    logic [COUNT_WIDTH-1:0]  r_cmp_act, n_cmp_act;
    logic [COUNT_WIDTH-1:0]  r_cmp_buf, n_cmp_buf;
    logic                    r_pin,     n_pin;
    logic                    r_ovf,     n_ovf;
    logic                    r_cmp,     n_cmp;
    logic [EXTEND_WIDTH-1:0] r_event,   n_event;

    logic                   match;
    logic                   at_max;
    logic                   bump;
    logic [COUNT_WIDTH-1:0] wr_val;

    assign match  = (r_count == r_cmp_act);
    assign at_max = (r_count == CMAX);
    assign wr_val = COUNT_WIDTH'(i_value);

    // Next state for one item
    always_comb begin
        n_count   = r_count;
        n_down    = r_down;
        n_cmp_act = r_cmp_act;
        n_cmp_buf = r_cmp_buf;
        n_pin     = r_pin;
        n_ovf     = r_ovf;
        n_cmp     = r_cmp;
        n_event   = r_event;
        bump      = 1'b0;

        if (i_fire) begin
            case (i_func)
                FN_TICK: begin
                    if (i_advance) begin
                        case (i_cfg.wave_mode)
                            WM_NORMAL: begin
                                if (match) begin
                                    n_cmp = 1'b1;
                                    case (i_cfg.output_mode)
                                        OM_TOGGLE: n_pin = ~r_pin;
                                        OM_CLEAR:  n_pin = 1'b0;
                                        OM_SET:    n_pin = 1'b1;
                                        default: ;
                                    endcase
                                end
                                if (at_max) begin
                                    n_count = '0;
                                    n_ovf   = 1'b1;
                                    bump    = 1'b1;
                                end else begin
                                    n_count = r_count + COUNT_WIDTH'(1);
                                end
                            end
                            WM_CTC: begin
                                if (match) begin
                                    n_cmp   = 1'b1;
                                    n_count = '0;
                                    bump    = 1'b1;
                                    case (i_cfg.output_mode)
                                        OM_TOGGLE: n_pin = ~r_pin;
                                        OM_CLEAR:  n_pin = 1'b0;
                                        OM_SET:    n_pin = 1'b1;
                                        default: ;
                                    endcase
                                end else if (at_max) begin
                                    n_count = '0;
                                    n_ovf   = 1'b1;
                                end else begin
                                    n_count = r_count + COUNT_WIDTH'(1);
                                end
                            end
                            WM_FAST_PWM: begin
                                if (match) begin
                                    n_cmp = 1'b1;
                                    case (i_cfg.output_mode)
                                        OM_CLEAR: n_pin = 1'b0;
                                        OM_SET:   n_pin = 1'b1;
                                        default: ;
                                    endcase
                                end
                                // wrap action overrides the match action
                                if (at_max) begin
                                    n_count   = '0;
                                    n_ovf     = 1'b1;
                                    n_cmp_act = r_cmp_buf;
                                    case (i_cfg.output_mode)
                                        OM_CLEAR: n_pin = 1'b1;
                                        OM_SET:   n_pin = 1'b0;
                                        default: ;
                                    endcase
                                end else begin
                                    n_count = r_count + COUNT_WIDTH'(1);
                                end
                            end
                            default: begin
                                // phase-correct PWM
                                if (match) begin
                                    n_cmp = 1'b1;
                                    case (i_cfg.output_mode)
                                        OM_CLEAR: n_pin = r_down;
                                        OM_SET:   n_pin = ~r_down;
                                        default: ;
                                    endcase
                                end
                                if (!r_down) begin
                                    if (at_max) begin
                                        // odd position: turn without flag
                                        n_down  = 1'b1;
                                        n_count = CMAX - COUNT_WIDTH'(1);
                                    end else begin
                                        n_count = r_count + COUNT_WIDTH'(1);
                                        if (r_count == CMAX - COUNT_WIDTH'(1)) begin
                                            n_down    = 1'b1;
                                            n_cmp_act = r_cmp_buf;
                                        end
                                    end
                                end else begin
                                    if (r_count == '0) begin
                                        // odd position: turn without flag
                                        n_down  = 1'b0;
                                        n_count = COUNT_WIDTH'(1);
                                    end else begin
                                        n_count = r_count - COUNT_WIDTH'(1);
                                        if (r_count == COUNT_WIDTH'(1)) begin
                                            n_down = 1'b0;
                                            n_ovf  = 1'b1;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
                FN_WR_COUNT: begin
                    n_count = wr_val;
                end
                FN_WR_COMPARE: begin
                    n_cmp_buf = wr_val;
                    if (i_cfg.wave_mode == WM_NORMAL || i_cfg.wave_mode == WM_CTC) begin
                        n_cmp_act = wr_val;
                    end
                end
                FN_CLEAR_FLAGS: begin
                    if (i_value[0]) n_ovf = 1'b0;
                    if (i_value[1]) n_cmp = 1'b0;
                end
                FN_RESET_COUNTS: begin
                    n_count = '0;
                    n_event = '0;
                end
                default: ;
            endcase

            if (bump && i_cfg.ext_en) begin
                n_event = r_event + EXTEND_WIDTH'(1);
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_down    <= 1'b0;
            r_cmp_act <= '0;
            r_cmp_buf <= '0;
            r_pin     <= 1'b0;
            r_ovf     <= 1'b0;
            r_cmp     <= 1'b0;
            r_event   <= '0;
        end else begin
            r_count   <= n_count;
            r_down    <= n_down;
            r_cmp_act <= n_cmp_act;
            r_cmp_buf <= n_cmp_buf;
            r_pin     <= n_pin;
            r_ovf     <= n_ovf;
            r_cmp     <= n_cmp;
            r_event   <= n_event;
        end
    end

    assign o_count   = n_count;
    assign o_compare = n_cmp_act;
    assign o_pin     = n_pin;
    assign o_ovf     = n_ovf;
    assign o_cmp     = n_cmp;
    assign o_event   = n_event;

`ifndef SYNTHESIS
    // a flag clear item never sets a flag, so a cleared overflow flag stays clear
    a_clear_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_func == FN_CLEAR_FLAGS && i_value[0]) |=> !r_ovf)
        else $error("overflow flag not cleared");
    a_reset_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_func == FN_RESET_COUNTS) |=> (r_count == '0 && r_event == '0))
        else $error("counts not reset");
    a_cmp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_cmp_act) && $stable(r_count) && $stable(r_event))
        else $error("timer state moved without a transfer");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_func == FN_TICK && i_advance && i_cfg.wave_mode == WM_PC_PWM
         && !r_down && r_count == CMAX - COUNT_WIDTH'(1)) |=> r_down)
        else $error("phase-correct top not turned");
`endif

endmodule
